// File: rtl/srs_pkg.sv
package srs_pkg;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int RADIUS_W   = 25;
    localparam int INT_W      = 16;
    localparam int ISUM_W     = 28;
    localparam int D2_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int CNT_PORT_W = 13;
    localparam int CFG_W      = 25;
    localparam int CFG_IDX_W  = 2;

    // Default ray limit per spot
    localparam int MAX_RAYS_DEF = 4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTROID_X = 2'd0,
        CFG_CENTROID_Y = 2'd1,
        CFG_CENTROID_Z = 2'd2,
        CFG_ENCIRCLE_R = 2'd3
    } cfg_index_t;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_R
    } mul_src_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_R,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROOT_MAX_START,
        ST_ROOT_MAX_WAIT,
        ST_ROOT_MEAN_START,
        ST_ROOT_MEAN_WAIT,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_src_t mul_sel;
        logic     d2_load;
        logic     d2_add;
        logic     update;
        logic     div_start;
        logic     sqrt_start;
        logic     sqrt_sel_mean;
        logic     cap_max;
        logic     out_load;
    } srs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } srs_status_t;

endpackage

// File: rtl/srs_divider.sv
module srs_divider #(
    parameter int DIVIDEND_W = 63,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;

    // One quotient bit per cycle, restoring
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quot_reg[DIVIDEND_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = DIVISOR_W'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/srs_sqrt.sv
module srs_sqrt #(
    parameter int N_W = 50
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [N_W-1:0]     radicand,
    output logic               done,
    output logic [N_W/2-1:0]   root
);

    localparam int R_W   = N_W / 2;
    localparam int REM_W = R_W + 3;
    localparam int CNT_W = (R_W > 1) ? $clog2(R_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [R_W-1:0]   res_reg, res_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    // Two radicand bits per step, round to nearest on the final step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        res_next  = res_reg;
        rem_sh    = {rem_reg[REM_W-3:0], n_reg[N_W-1:N_W-2]};
        trial     = REM_W'({root_reg, 2'b01});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            n_next = {n_reg[N_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[R_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[R_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(R_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // remainder is n - r*r; bump when it exceeds r
                if (rem_next > REM_W'(root_next)) begin
                    res_next = R_W'(root_next + 1'b1);
                end else begin
                    res_next = root_next;
                end
            end else begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

// File: rtl/srs_datapath.sv
module srs_datapath #(
    parameter int MAX_RAYS = srs_pkg::MAX_RAYS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_z,
    input  logic [srs_pkg::INT_W-1:0]           s_ray_intensity,
    input  logic                                s_last_ray,
    input  srs_pkg::srs_cmd_t                   cmd,
    output srs_pkg::srs_status_t                status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [srs_pkg::ROOT_W-1:0]          m_max_radius,
    output logic [srs_pkg::ROOT_W-1:0]          m_rms_radius,
    output logic [srs_pkg::ISUM_W-1:0]          m_total_intensity,
    output logic [srs_pkg::ISUM_W-1:0]          m_encircled_intensity,
    output logic [srs_pkg::CNT_PORT_W-1:0]      m_ray_count,
    output logic                                m_count_overflow
);

    import srs_pkg::*;

    localparam int CNT_W = $clog2(MAX_RAYS + 1);
    localparam int SUM_W = D2_W + CNT_W;

    // Configuration
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RADIUS_W-1:0]       radius_reg;

    // Captured request
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic [INT_W-1:0]          inten_reg;
    logic                      last_reg;

    // Squared distance datapath
    logic signed [DIFF_W:0]    mul_a;
    logic signed [2*DIFF_W+1:0] mul_full;
    logic [D2_W-1:0]           prod_reg;
    logic [D2_W-1:0]           d2_reg, d2_next;

    // Accumulators
    logic [D2_W-1:0]           max_sq_reg, max_sq_next;
    logic [SUM_W-1:0]          sum_sq_reg, sum_sq_next;
    logic [ISUM_W-1:0]         isum_reg, isum_next;
    logic [ISUM_W-1:0]         esum_reg, esum_next;
    logic [CNT_W-1:0]          rays_reg, rays_next;
    logic                      ovf_reg, ovf_next;

    // Finish units
    logic                      div_done;
    logic [SUM_W-1:0]          quot;
    logic [D2_W-1:0]           mean_sq;
    logic [D2_W-1:0]           sqrt_in;
    logic                      sqrt_done;
    logic [ROOT_W-1:0]         sqrt_root;
    logic [ROOT_W-1:0]         root_max_reg;

    // Output register
    logic                      m_valid_reg, m_valid_next;
    logic [ROOT_W-1:0]         max_r_reg, rms_r_reg;
    logic [ISUM_W-1:0]         tot_reg, enc_reg;
    logic [CNT_PORT_W-1:0]     cnt_out_reg;
    logic                      ovf_out_reg;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTROID_X: cx_reg     <= cfg_data[COORD_W-1:0];
                CFG_CENTROID_Y: cy_reg     <= cfg_data[COORD_W-1:0];
                CFG_CENTROID_Z: cz_reg     <= cfg_data[COORD_W-1:0];
                CFG_ENCIRCLE_R: radius_reg <= cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture request, take coordinate differences against the centroid
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg    <= DIFF_W'(s_point_x) - DIFF_W'(cx_reg);
            dy_reg    <= DIFF_W'(s_point_y) - DIFF_W'(cy_reg);
            dz_reg    <= DIFF_W'(s_point_z) - DIFF_W'(cz_reg);
            inten_reg <= s_ray_intensity;
            last_reg  <= s_last_ray;
        end
    end

    // Shared squarer: dx, dy, dz, then the encircle radius
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_X:   mul_a = (DIFF_W+1)'(dx_reg);
            MUL_Y:   mul_a = (DIFF_W+1)'(dy_reg);
            MUL_Z:   mul_a = (DIFF_W+1)'(dz_reg);
            MUL_R:   mul_a = $signed({1'b0, radius_reg});
            default: mul_a = '0;
        endcase
        mul_full = mul_a * mul_a;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_full[D2_W-1:0];
        end
        d2_reg <= d2_next;
    end

    always_comb begin
        d2_next = d2_reg;
        if (cmd.d2_load) begin
            d2_next = prod_reg;
        end else if (cmd.d2_add) begin
            d2_next = D2_W'(d2_reg + prod_reg);
        end
    end

    // Accumulator update; prod_reg holds radius squared at this point
    always_comb begin
        max_sq_next = max_sq_reg;
        sum_sq_next = sum_sq_reg;
        isum_next   = isum_reg;
        esum_next   = esum_reg;
        rays_next   = rays_reg;
        ovf_next    = ovf_reg;
        if (cmd.out_load) begin
            max_sq_next = '0;
            sum_sq_next = '0;
            isum_next   = '0;
            esum_next   = '0;
            rays_next   = '0;
            ovf_next    = 1'b0;
        end else if (cmd.update) begin
            if (rays_reg >= CNT_W'(MAX_RAYS)) begin
                // spot full: ray only flags overflow
                ovf_next = 1'b1;
            end else begin
                if (d2_reg > max_sq_reg) begin
                    max_sq_next = d2_reg;
                end
                sum_sq_next = SUM_W'(sum_sq_reg + SUM_W'(d2_reg));
                isum_next   = ISUM_W'(isum_reg + ISUM_W'(inten_reg));
                if (d2_reg <= prod_reg) begin
                    esum_next = ISUM_W'(esum_reg + ISUM_W'(inten_reg));
                end
                rays_next = CNT_W'(rays_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_sq_reg <= '0;
            sum_sq_reg <= '0;
            isum_reg   <= '0;
            esum_reg   <= '0;
            rays_reg   <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            max_sq_reg <= max_sq_next;
            sum_sq_reg <= sum_sq_next;
            isum_reg   <= isum_next;
            esum_reg   <= esum_next;
            rays_reg   <= rays_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Mean square and roots
    srs_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_sq_reg),
        .divisor  (rays_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // quotient never exceeds the largest squared distance
    assign mean_sq = (rays_reg == '0) ? '0 : quot[D2_W-1:0];
    assign sqrt_in = cmd.sqrt_sel_mean ? mean_sq : max_sq_reg;

    srs_sqrt #(
        .N_W (D2_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap_max) begin
            root_max_reg <= sqrt_root;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.out_load) begin
            max_r_reg   <= root_max_reg;
            rms_r_reg   <= sqrt_root;
            tot_reg     <= isum_reg;
            enc_reg     <= esum_reg;
            cnt_out_reg <= CNT_PORT_W'(rays_reg);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign status.last      = last_reg;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid               = m_valid_reg;
    assign m_max_radius          = max_r_reg;
    assign m_rms_radius          = rms_r_reg;
    assign m_total_intensity     = tot_reg;
    assign m_encircled_intensity = enc_reg;
    assign m_ray_count           = cnt_out_reg;
    assign m_count_overflow      = ovf_out_reg;

`ifndef SYNTHESIS
    a_rays_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        rays_reg <= CNT_W'(MAX_RAYS))
        else $error("ray count above limit");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (rays_reg == CNT_W'(MAX_RAYS)))
        else $error("overflow flagged before spot full");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid_reg && rays_reg == '0 && !ovf_reg))
        else $error("emit did not load output and clear accumulators");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (rays_reg != '0))
        else $error("divide started with empty spot");
`endif

endmodule

// File: rtl/srs_ctrl.sv
module srs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srs_pkg::srs_status_t status,
    output srs_pkg::srs_cmd_t    cmd
);

    import srs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:            if (s_valid) state_next = ST_SQ_X;
            ST_SQ_X:            state_next = ST_SQ_Y;
            ST_SQ_Y:            state_next = ST_SQ_Z;
            ST_SQ_Z:            state_next = ST_SQ_R;
            ST_SQ_R:            state_next = ST_UPDATE;
            ST_UPDATE:          state_next = status.last ? ST_DIV_START : ST_IDLE;
            ST_DIV_START:       state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:        if (status.div_done) state_next = ST_ROOT_MAX_START;
            ST_ROOT_MAX_START:  state_next = ST_ROOT_MAX_WAIT;
            ST_ROOT_MAX_WAIT:   if (status.sqrt_done) state_next = ST_ROOT_MEAN_START;
            ST_ROOT_MEAN_START: state_next = ST_ROOT_MEAN_WAIT;
            ST_ROOT_MEAN_WAIT:  if (status.sqrt_done) state_next = ST_EMIT;
            ST_EMIT:            if (status.out_free) state_next = ST_IDLE;
            default:            state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SQ_X: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X;
            end
            ST_SQ_Y: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y;
                cmd.d2_load = 1'b1;
            end
            ST_SQ_Z: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Z;
                cmd.d2_add  = 1'b1;
            end
            ST_SQ_R: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_R;
                cmd.d2_add  = 1'b1;
            end
            ST_UPDATE:          cmd.update = 1'b1;
            ST_DIV_START:       cmd.div_start = 1'b1;
            ST_DIV_WAIT:        ;
            ST_ROOT_MAX_START:  cmd.sqrt_start = 1'b1;
            ST_ROOT_MAX_WAIT:   cmd.cap_max = status.sqrt_done;
            ST_ROOT_MEAN_START: begin
                cmd.sqrt_start    = 1'b1;
                cmd.sqrt_sel_mean = 1'b1;
            end
            ST_ROOT_MEAN_WAIT:  cmd.sqrt_sel_mean = 1'b1;
            ST_EMIT:            cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/spot_radius_statistics.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    point_x/y/z, ray_intensity, last_ray
// m_        out  m_valid/m_ready    max/rms radius, intensities, ray_count, overflow
// cfg_      in   cfg_wr_en          cfg_index, cfg_data (no wait, no read-back)
//
// Each ray goes through accept, four passes through the one shared
// squarer (dx, dy, dz, radius), then the accumulator update.
// A last ray adds the finish: a bit-serial divide (one cycle per bit of the
// 63-bit square sum at default MAX_RAYS) and two 25-step roots.
// Reset is synchronous, active low; it clears config and accumulators.
// A result waits in the output register; the next spot's rays are taken
// meanwhile, and only the next finish stalls until that result is taken.
module spot_radius_statistics #(
    parameter int MAX_RAYS = srs_pkg::MAX_RAYS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [srs_pkg::COORD_W-1:0]  s_point_z,
    input  logic [srs_pkg::INT_W-1:0]           s_ray_intensity,
    input  logic                                s_last_ray,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srs_pkg::ROOT_W-1:0]          m_max_radius,
    output logic [srs_pkg::ROOT_W-1:0]          m_rms_radius,
    output logic [srs_pkg::ISUM_W-1:0]          m_total_intensity,
    output logic [srs_pkg::ISUM_W-1:0]          m_encircled_intensity,
    output logic [srs_pkg::CNT_PORT_W-1:0]      m_ray_count,
    output logic                                m_count_overflow
);

    import srs_pkg::*;

    srs_cmd_t    cmd;
    srs_status_t status;

    // Sequencer
    srs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, accumulators, output register
    srs_datapath #(
        .MAX_RAYS (MAX_RAYS)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_point_x             (s_point_x),
        .s_point_y             (s_point_y),
        .s_point_z             (s_point_z),
        .s_ray_intensity       (s_ray_intensity),
        .s_last_ray            (s_last_ray),
        .cmd                   (cmd),
        .status                (status),
        .m_ready               (m_ready),
        .m_valid               (m_valid),
        .m_max_radius          (m_max_radius),
        .m_rms_radius          (m_rms_radius),
        .m_total_intensity     (m_total_intensity),
        .m_encircled_intensity (m_encircled_intensity),
        .m_ray_count           (m_ray_count),
        .m_count_overflow      (m_count_overflow)
    );

endmodule
